[design/quv_pkg.sv]
// Package for the textured quad clipper: payload structs, side-band struct,
// widths and the saturation helper. No dependencies.
package quv_pkg;

  localparam int DATA_W         = 32;
  localparam int EDGE_W         = 34;   // x + w, exact
  localparam int LEN_W          = 36;   // overlap and clipped-away lengths
  localparam int CLAMP_EXP      = 40;   // product magnitude limit is 2^40
  localparam int MAG_W          = CLAMP_EXP + 1;
  localparam int SUM_W          = MAG_W + 2;
  localparam int LANES          = 4;
  localparam int FRAC_BITS_DEF  = 16;

  // Product lanes
  localparam int LN_SX = 0;  // x origin shift
  localparam int LN_SY = 1;  // y origin shift
  localparam int LN_W  = 2;  // clipped width
  localparam int LN_H  = 3;  // clipped height

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_w;
    logic signed [DATA_W-1:0] pos_h;
    logic signed [DATA_W-1:0] tex_x;
    logic signed [DATA_W-1:0] tex_y;
    logic signed [DATA_W-1:0] tex_w;
    logic signed [DATA_W-1:0] tex_h;
    logic signed [DATA_W-1:0] clip_x;
    logic signed [DATA_W-1:0] clip_y;
    logic signed [DATA_W-1:0] clip_w;
    logic signed [DATA_W-1:0] clip_h;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;
    logic signed [DATA_W-1:0] out_w;
    logic signed [DATA_W-1:0] out_h;
    logic                     was_clipped;
  } out_t;

  // Data that rides alongside the ratio dividers
  typedef struct packed {
    logic signed [DATA_W-1:0] tx;
    logic signed [DATA_W-1:0] ty;
    logic signed [DATA_W-1:0] tw;
    logic signed [DATA_W-1:0] th;
    logic                     clip;
    logic                     shx;
    logic                     shy;
    logic                     zx;   // quad width is zero
    logic                     zy;
    logic                     rnx;  // ratio sign before zero check
    logic                     rny;
    logic signed [LEN_W-1:0]  lxs;
    logic signed [LEN_W-1:0]  lys;
    logic signed [LEN_W-1:0]  ow;
    logic signed [LEN_W-1:0]  oh;
  } side_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(signed'(64'sd2147483647));
    lo = SUM_W'(signed'(-64'sd2147483648));
    if (v > hi) return hi[DATA_W-1:0];
    else if (v < lo) return lo[DATA_W-1:0];
    else return v[DATA_W-1:0];
  endfunction

endpackage

[design/quad_uv_clip.sv]
// Top level of the textured quad clipper: geometry stages, pipelined ratio
// dividers and split multipliers. Depends on quv_pkg.
//
// Usage: one request on in_* carries a screen quad, its texture rectangle and
// a clip rectangle (signed fixed point, FRAC_BITS fraction bits). Each request
// gives exactly one result on out_*: the clipped texture rectangle and a flag
// set when a partial overlap changed it. Both channels are valid/ready.
// Pipeline: three geometry stages, one divider stage per quotient bit,
// 32 + FRAC_BITS of them, two multiply stages and the output register.
// Throughput: one request per cycle; the restoring divider is unrolled, one
// quotient bit per stage, so every stage holds a different request.
// Stall: while out_valid is high and out_ready low the whole pipeline holds,
// in_ready drops, and nothing is lost or repeated. Bubbles travel as cleared
// valid bits.
// Reset: rst_n (synchronous, active low) clears all stage valid bits; the
// block takes requests in the first cycle after reset.
module quad_uv_clip #(
  parameter int FRAC_BITS = quv_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  quv_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output quv_pkg::out_t  out_data
);

  localparam int DW = quv_pkg::DATA_W + FRAC_BITS;   // dividend and quotient
  localparam int RL = DW / 2;
  localparam int RH = DW - RL;
  localparam int LW = quv_pkg::LEN_W;
  localparam int PW = LW + DW;
  localparam int EW = quv_pkg::EDGE_W;
  localparam int OW = quv_pkg::LEN_W - 1;

  typedef struct packed {
    logic [DW-1:0]                 dvd_x;
    logic [DW-1:0]                 quo_x;
    logic [quv_pkg::DATA_W-1:0]    rem_x;
    logic [quv_pkg::DATA_W-1:0]    dsr_x;
    logic [DW-1:0]                 dvd_y;
    logic [DW-1:0]                 quo_y;
    logic [quv_pkg::DATA_W-1:0]    rem_y;
    logic [quv_pkg::DATA_W-1:0]    dsr_y;
  } dv_t;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage G1: register request and far edges
  quv_pkg::in_t          g1_r;
  logic signed [EW-1:0]  g1_epx_r, g1_epy_r, g1_ecx_r, g1_ecy_r;
  logic                  g1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_v_r <= 1'b0;
    end else if (en) begin
      g1_v_r <= in_valid;
    end
    if (en) begin
      g1_r     <= in_data;
      g1_epx_r <= EW'(in_data.pos_x) + EW'(in_data.pos_w);
      g1_epy_r <= EW'(in_data.pos_y) + EW'(in_data.pos_h);
      g1_ecx_r <= EW'(in_data.clip_x) + EW'(in_data.clip_w);
      g1_ecy_r <= EW'(in_data.clip_y) + EW'(in_data.clip_h);
    end
  end

  // Stage G2: edge tests and overlap extent
  logic signed [EW-1:0] pxe, pye, cxe, cye;
  logic inpx, inex, covx, inpy, iney, covy;
  logic ovl, ins;
  logic signed [EW-1:0] minx, miny, maxx, maxy;
  logic signed [OW-1:0] ow_c, oh_c;

  always_comb begin
    pxe  = EW'(g1_r.pos_x);
    pye  = EW'(g1_r.pos_y);
    cxe  = EW'(g1_r.clip_x);
    cye  = EW'(g1_r.clip_y);
    inpx = (pxe >= cxe) && (pxe <= g1_ecx_r);
    inex = (g1_epx_r >= cxe) && (g1_epx_r <= g1_ecx_r);
    covx = (pxe <= cxe) && (g1_epx_r >= g1_ecx_r);
    inpy = (pye >= cye) && (pye <= g1_ecy_r);
    iney = (g1_epy_r >= cye) && (g1_epy_r <= g1_ecy_r);
    covy = (pye <= cye) && (g1_epy_r >= g1_ecy_r);
    ovl  = (inpx || inex || covx) && (inpy || iney || covy);
    ins  = inpx && inex && inpy && iney;
    minx = (pxe > cxe) ? pxe : cxe;
    miny = (pye > cye) ? pye : cye;
    maxx = (g1_epx_r < g1_ecx_r) ? g1_epx_r : g1_ecx_r;
    maxy = (g1_epy_r < g1_ecy_r) ? g1_epy_r : g1_ecy_r;
    ow_c = OW'(maxx) - OW'(minx);
    oh_c = OW'(maxy) - OW'(miny);
  end

  quv_pkg::in_t          g2_r;
  logic                  g2_v_r, g2_clip_r, g2_shx_r, g2_shy_r;
  logic signed [OW-1:0]  g2_ow_r, g2_oh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g2_v_r <= 1'b0;
    end else if (en) begin
      g2_v_r <= g1_v_r;
    end
    if (en) begin
      g2_r      <= g1_r;
      g2_clip_r <= ovl && !ins;
      g2_shx_r  <= !inpx;
      g2_shy_r  <= !inpy;
      g2_ow_r   <= ow_c;
      g2_oh_r   <= oh_c;
    end
  end

  // Stage G3: clipped-away lengths and divider operands
  quv_pkg::side_t  side_r [DW+1];
  dv_t             dv_r   [DW+1];
  logic [DW:0]     dv_v_r;
  logic [quv_pkg::DATA_W-1:0] atw, ath, apw, aph;

  always_comb begin
    atw = g2_r.tex_w[quv_pkg::DATA_W-1] ? -g2_r.tex_w : g2_r.tex_w;
    ath = g2_r.tex_h[quv_pkg::DATA_W-1] ? -g2_r.tex_h : g2_r.tex_h;
    apw = g2_r.pos_w[quv_pkg::DATA_W-1] ? -g2_r.pos_w : g2_r.pos_w;
    aph = g2_r.pos_h[quv_pkg::DATA_W-1] ? -g2_r.pos_h : g2_r.pos_h;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= g2_v_r;
    end
    if (en) begin
      side_r[0].tx   <= g2_r.tex_x;
      side_r[0].ty   <= g2_r.tex_y;
      side_r[0].tw   <= g2_r.tex_w;
      side_r[0].th   <= g2_r.tex_h;
      side_r[0].clip <= g2_clip_r;
      side_r[0].shx  <= g2_shx_r;
      side_r[0].shy  <= g2_shy_r;
      side_r[0].zx   <= (g2_r.pos_w == '0);
      side_r[0].zy   <= (g2_r.pos_h == '0);
      side_r[0].rnx  <= g2_r.tex_w[quv_pkg::DATA_W-1] ^ g2_r.pos_w[quv_pkg::DATA_W-1];
      side_r[0].rny  <= g2_r.tex_h[quv_pkg::DATA_W-1] ^ g2_r.pos_h[quv_pkg::DATA_W-1];
      side_r[0].lxs  <= LW'(g2_r.pos_w) - LW'(g2_ow_r);
      side_r[0].lys  <= LW'(g2_r.pos_h) - LW'(g2_oh_r);
      side_r[0].ow   <= LW'(g2_ow_r);
      side_r[0].oh   <= LW'(g2_oh_r);
      dv_r[0].dvd_x  <= {atw, FRAC_BITS'(0)};
      dv_r[0].dvd_y  <= {ath, FRAC_BITS'(0)};
      dv_r[0].quo_x  <= '0;
      dv_r[0].quo_y  <= '0;
      dv_r[0].rem_x  <= '0;
      dv_r[0].rem_y  <= '0;
      dv_r[0].dsr_x  <= apw;
      dv_r[0].dsr_y  <= aph;
    end
  end

  // Divider stages: one restoring quotient bit per stage, MSB first
  for (genvar k = 0; k < DW; k++) begin : g_div
    dv_t dv_nxt;
    logic [quv_pkg::DATA_W:0] trx, try_;
    logic bx, by;

    always_comb begin
      trx    = {dv_r[k].rem_x, dv_r[k].dvd_x[DW-1]};
      try_   = {dv_r[k].rem_y, dv_r[k].dvd_y[DW-1]};
      bx     = trx >= {1'b0, dv_r[k].dsr_x};
      by     = try_ >= {1'b0, dv_r[k].dsr_y};
      dv_nxt = dv_r[k];
      dv_nxt.dvd_x = {dv_r[k].dvd_x[DW-2:0], 1'b0};
      dv_nxt.dvd_y = {dv_r[k].dvd_y[DW-2:0], 1'b0};
      dv_nxt.quo_x = {dv_r[k].quo_x[DW-2:0], bx};
      dv_nxt.quo_y = {dv_r[k].quo_y[DW-2:0], by};
      dv_nxt.rem_x = bx ? quv_pkg::DATA_W'(trx - {1'b0, dv_r[k].dsr_x})
                        : quv_pkg::DATA_W'(trx);
      dv_nxt.rem_y = by ? quv_pkg::DATA_W'(try_ - {1'b0, dv_r[k].dsr_y})
                        : quv_pkg::DATA_W'(try_);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
      if (en) begin
        dv_r[k+1]   <= dv_nxt;
        side_r[k+1] <= side_r[k];
      end
    end
  end

  // Stage M1: length magnitudes and low partial products
  quv_pkg::side_t sd;
  logic [DW-1:0]  rx, ry;
  logic [LW-1:0]  lmag [quv_pkg::LANES];
  logic           lneg [quv_pkg::LANES];
  logic [DW-1:0]  lrat [quv_pkg::LANES];
  logic signed [LW-1:0] llen [quv_pkg::LANES];

  always_comb begin
    sd = side_r[DW];
    rx = sd.zx ? '0 : dv_r[DW].quo_x;
    ry = sd.zy ? '0 : dv_r[DW].quo_y;
    llen[quv_pkg::LN_SX] = sd.lxs;
    llen[quv_pkg::LN_SY] = sd.lys;
    llen[quv_pkg::LN_W]  = sd.ow;
    llen[quv_pkg::LN_H]  = sd.oh;
    lrat[quv_pkg::LN_SX] = rx;
    lrat[quv_pkg::LN_SY] = ry;
    lrat[quv_pkg::LN_W]  = rx;
    lrat[quv_pkg::LN_H]  = ry;
    lneg[quv_pkg::LN_SX] = sd.lxs[LW-1] ^ sd.rnx;
    lneg[quv_pkg::LN_SY] = sd.lys[LW-1] ^ sd.rny;
    lneg[quv_pkg::LN_W]  = sd.ow[LW-1] ^ sd.rnx;
    lneg[quv_pkg::LN_H]  = sd.oh[LW-1] ^ sd.rny;
    for (int j = 0; j < quv_pkg::LANES; j++) begin
      lmag[j] = llen[j][LW-1] ? LW'(-llen[j]) : LW'(llen[j]);
    end
  end

  quv_pkg::side_t m1_sd_r;
  logic           m1_v_r;
  logic [LW-1:0]  m1_mag_r [quv_pkg::LANES];
  logic [RH-1:0]  m1_rhi_r [quv_pkg::LANES];
  logic [LW+RL-1:0] m1_pl_r [quv_pkg::LANES];
  logic           m1_neg_r [quv_pkg::LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= dv_v_r[DW];
    end
    if (en) begin
      m1_sd_r <= sd;
      for (int j = 0; j < quv_pkg::LANES; j++) begin
        m1_mag_r[j] <= lmag[j];
        m1_rhi_r[j] <= lrat[j][DW-1:RL];
        m1_neg_r[j] <= lneg[j];
        m1_pl_r[j]  <= (LW+RL)'(lmag[j]) * (LW+RL)'(lrat[j][RL-1:0]);
      end
    end
  end

  // Stage M2: high partial products and full magnitude
  quv_pkg::side_t m2_sd_r;
  logic           m2_v_r;
  logic [PW-1:0]  m2_pf_r  [quv_pkg::LANES];
  logic           m2_neg_r [quv_pkg::LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else if (en) begin
      m2_v_r <= m1_v_r;
    end
    if (en) begin
      m2_sd_r <= m1_sd_r;
      for (int j = 0; j < quv_pkg::LANES; j++) begin
        m2_neg_r[j] <= m1_neg_r[j];
        m2_pf_r[j]  <= PW'(m1_pl_r[j]) +
                       (PW'(PW'(m1_mag_r[j]) * PW'(m1_rhi_r[j])) << RL);
      end
    end
  end

  // Stage M3: scale, clamp, sign, add origin, saturate; unclipped requests pass the texture rectangle through
  logic [PW-1:0]                  shv  [quv_pkg::LANES];
  logic [quv_pkg::MAG_W-1:0]      cmag [quv_pkg::LANES];
  logic signed [quv_pkg::SUM_W-1:0] sval [quv_pkg::LANES];
  logic signed [quv_pkg::SUM_W-1:0] nx, ny;
  quv_pkg::out_t                  res;

  always_comb begin
    for (int j = 0; j < quv_pkg::LANES; j++) begin
      shv[j] = m2_pf_r[j] >> FRAC_BITS;
      if ((|shv[j][PW-1:quv_pkg::MAG_W]) ||
          (shv[j][quv_pkg::CLAMP_EXP] && (|shv[j][quv_pkg::CLAMP_EXP-1:0]))) begin
        cmag[j] = quv_pkg::MAG_W'(1) << quv_pkg::CLAMP_EXP;
      end else begin
        cmag[j] = shv[j][quv_pkg::MAG_W-1:0];
      end
      sval[j] = m2_neg_r[j] ? -quv_pkg::SUM_W'(cmag[j]) : quv_pkg::SUM_W'(cmag[j]);
    end
    nx = quv_pkg::SUM_W'(m2_sd_r.tx) + (m2_sd_r.shx ? sval[quv_pkg::LN_SX] : '0);
    ny = quv_pkg::SUM_W'(m2_sd_r.ty) + (m2_sd_r.shy ? sval[quv_pkg::LN_SY] : '0);
    if (m2_sd_r.clip) begin
      res.out_x       = quv_pkg::sat32(nx);
      res.out_y       = quv_pkg::sat32(ny);
      res.out_w       = quv_pkg::sat32(sval[quv_pkg::LN_W]);
      res.out_h       = quv_pkg::sat32(sval[quv_pkg::LN_H]);
      res.was_clipped = 1'b1;
    end else begin
      res.out_x       = m2_sd_r.tx;
      res.out_y       = m2_sd_r.ty;
      res.out_w       = m2_sd_r.tw;
      res.out_h       = m2_sd_r.th;
      res.was_clipped = 1'b0;
    end
  end

  quv_pkg::out_t out_data_r;
  logic          out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= m2_v_r;
    end
    if (en) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_hold_div: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(dv_v_r) && $stable(m1_v_r) && $stable(m2_v_r))
    else $error("pipeline moved while output stalled");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> (dv_v_r == '0) && !g1_v_r && !g2_v_r && !out_valid)
    else $error("stage valid bits not cleared by reset");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |=> (out_valid == $past(m2_v_r)) && (m1_v_r == $past(dv_v_r[DW])))
    else $error("valid bit lost between stages");

endmodule
